[rtl/tabt_pkg.sv]
// Shared types, constants and codes for the traffic-aware buffer threshold block.
package tabt_pkg;

    localparam int NUM_PORTS_DEF = 16;
    localparam int LEN_W         = 16;
    localparam int PORT_W        = 4;
    localparam int OCC_W         = 20;
    localparam int ALPHA_W       = 12;
    localparam int BWIN_W        = 17;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 17;
    localparam int QUEUE_DEPTH   = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUFFER_SIZE   = 3'd0,
        REG_ALPHA_Q8      = 3'd1,
        REG_DEQ_RUN_LIM   = 3'd2,
        REG_ENQ_BURST_LIM = 3'd3,
        REG_NORM_WIN_LIM  = 3'd4,
        REG_BURST_WIN_LIM = 3'd5,
        REG_DROP_EVAC_LIM = 3'd6,
        REG_MODE_TA       = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_BURST  = 2'd1,
        MODE_EVAC   = 2'd2
    } port_mode_t;

    typedef enum logic {
        KIND_CHANGE = 1'b0,
        KIND_DROP   = 1'b1
    } event_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CALC,
        ST_DIV,
        ST_SWEEP
    } eng_state_t;

    typedef struct packed {
        event_kind_t       kind;
        logic [PORT_W-1:0] port;
        logic [LEN_W-1:0]  old_length;
        logic [LEN_W-1:0]  new_length;
    } event_t;

    typedef struct packed {
        logic [PORT_W-1:0] out_port;
        logic [LEN_W-1:0]  threshold;
        port_mode_t        out_mode;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [LEN_W-1:0]   buffer_size;
        logic [ALPHA_W-1:0] alpha_q8;
        logic [LEN_W-1:0]   dequeue_run_limit;
        logic [LEN_W-1:0]   enqueue_burst_limit;
        logic [LEN_W-1:0]   normal_window_limit;
        logic [BWIN_W-1:0]  burst_window_limit;
        logic [LEN_W-1:0]   drop_evac_limit;
        logic               mode_traffic_aware;
    } cfg_t;

endpackage

[rtl/traffic_aware_buffer_threshold_top.sv]
// Top level: configuration registers, event front end, engine and result queue.
//
// Each accepted queue-length-change event yields NUM_PORTS results, one per port in
// ascending order, with last set on the final one; a drop event yields none, and an
// event for a port at or above NUM_PORTS is accepted and discarded. A change event
// runs the update, the threshold calculation, the per-port sweep and, when any port
// is in burst mode, the serial divider that forms buffer_size over the burst port
// count; a drop event runs the update only. A two-entry event queue and a two-entry
// result queue let input and output stall independently. Configuration writes are
// always ready and must only be issued while no event is pending.
module traffic_aware_buffer_threshold_top #(
    parameter int NUM_PORTS = tabt_pkg::NUM_PORTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               kind,
    input  logic [tabt_pkg::PORT_W-1:0]        port,
    input  logic [tabt_pkg::LEN_W-1:0]         old_length,
    input  logic [tabt_pkg::LEN_W-1:0]         new_length,
    output logic                               empty,
    input  logic                               pop,
    output logic [tabt_pkg::PORT_W-1:0]        out_port,
    output logic [tabt_pkg::LEN_W-1:0]         threshold,
    output logic [1:0]                         out_mode,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tabt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tabt_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tabt_pkg::*;

    localparam int RES_W = $bits(result_t);

    cfg_t             cfg_reg;
    event_t           in_evt;
    event_t           evt_head;
    logic             evt_empty, evt_pop;
    result_t          res, res_head;
    logic             res_push, res_full;
    logic [RES_W-1:0] res_bits;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.buffer_size         <= LEN_W'(667);
            cfg_reg.alpha_q8            <= ALPHA_W'(256);
            cfg_reg.dequeue_run_limit   <= LEN_W'(3);
            cfg_reg.enqueue_burst_limit <= LEN_W'(41);
            cfg_reg.normal_window_limit <= LEN_W'(41);
            cfg_reg.burst_window_limit  <= BWIN_W'(1334);
            cfg_reg.drop_evac_limit     <= LEN_W'(333);
            cfg_reg.mode_traffic_aware  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_BUFFER_SIZE:   cfg_reg.buffer_size         <= cfg_data[LEN_W-1:0];
                REG_ALPHA_Q8:      cfg_reg.alpha_q8            <= cfg_data[ALPHA_W-1:0];
                REG_DEQ_RUN_LIM:   cfg_reg.dequeue_run_limit   <= cfg_data[LEN_W-1:0];
                REG_ENQ_BURST_LIM: cfg_reg.enqueue_burst_limit <= cfg_data[LEN_W-1:0];
                REG_NORM_WIN_LIM:  cfg_reg.normal_window_limit <= cfg_data[LEN_W-1:0];
                REG_BURST_WIN_LIM: cfg_reg.burst_window_limit  <= cfg_data[BWIN_W-1:0];
                REG_DROP_EVAC_LIM: cfg_reg.drop_evac_limit     <= cfg_data[LEN_W-1:0];
                REG_MODE_TA:       cfg_reg.mode_traffic_aware  <= cfg_data[0];
                default:           cfg_reg.mode_traffic_aware  <= cfg_reg.mode_traffic_aware;
            endcase
        end
    end

    assign in_evt.kind       = event_kind_t'(kind);
    assign in_evt.port       = port;
    assign in_evt.old_length = old_length;
    assign in_evt.new_length = new_length;

    tabt_front #(
        .NUM_PORTS (NUM_PORTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_evt    (in_evt),
        .evt_pop   (evt_pop),
        .evt_head  (evt_head),
        .evt_empty (evt_empty)
    );

    tabt_engine #(
        .NUM_PORTS (NUM_PORTS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .evt_head  (evt_head),
        .evt_empty (evt_empty),
        .evt_pop   (evt_pop),
        .res       (res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    tabt_fifo #(
        .W     (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_bits),
        .empty   (empty)
    );

    assign res_head  = result_t'(res_bits);
    assign out_port  = res_head.out_port;
    assign threshold = res_head.threshold;
    assign out_mode  = res_head.out_mode;
    assign last      = res_head.last;

endmodule

[rtl/tabt_fifo.sv]
// Small first-in first-out queue of register entries.
module tabt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/tabt_front.sv]
// Front end: accepts events, drops those for absent ports, queues the rest.
module tabt_front #(
    parameter int NUM_PORTS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  tabt_pkg::event_t in_evt,
    input  logic            evt_pop,
    output tabt_pkg::event_t evt_head,
    output logic            evt_empty
);
    import tabt_pkg::*;

    localparam int EVT_W = $bits(event_t);

    logic             port_ok;
    logic [EVT_W-1:0] head_bits;

    // Classify: only ports that exist enter the queue
    assign port_ok  = (32'(in_evt.port) < NUM_PORTS);
    assign evt_head = event_t'(head_bits);

    tabt_fifo #(
        .W     (EVT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_evt_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && port_ok),
        .wr_data (in_evt),
        .full    (full),
        .rd_en   (evt_pop),
        .rd_data (head_bits),
        .empty   (evt_empty)
    );

endmodule

[rtl/tabt_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module tabt_div #(
    parameter int DW = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tabt_pkg::LEN_W-1:0]   dividend,
    input  logic [DW-1:0]                divisor,
    output logic [tabt_pkg::LEN_W-1:0]   quotient,
    output logic                         done
);
    import tabt_pkg::*;

    localparam int CW = $clog2(LEN_W);

    logic [DW-1:0]    dsr_reg;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [LEN_W-1:0] quo_reg, quo_next;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;
    logic [DW:0]      shifted;
    logic             fits;

    assign quotient = quo_reg;
    assign done     = done_reg;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[LEN_W-1]};
        fits     = (shifted >= {1'b0, dsr_reg});
        rem_next = fits ? DW'(shifted - {1'b0, dsr_reg}) : DW'(shifted);
        quo_next = {quo_reg[LEN_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(LEN_W-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

[rtl/tabt_engine.sv]
// Back end: per-port counters and modes, occupancy, and the threshold sweep.
module tabt_engine #(
    parameter int NUM_PORTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tabt_pkg::cfg_t    cfg,
    input  tabt_pkg::event_t  evt_head,
    input  logic              evt_empty,
    output logic              evt_pop,
    output tabt_pkg::result_t res,
    output logic              res_push,
    input  logic              res_full
);
    import tabt_pkg::*;

    localparam int IW    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int BCW   = $clog2(NUM_PORTS + 1);
    localparam int SUM_W = LEN_W + IW;
    localparam int PROD_W = ALPHA_W + LEN_W;
    // Reciprocal of the port count, exact for every 16-bit buffer size
    localparam int     SHR_K = LEN_W + IW;
    localparam longint SHR_M = ((longint'(1) << SHR_K) + longint'(NUM_PORTS) - 1)
                               / longint'(NUM_PORTS);

    eng_state_t state_reg, state_next;

    port_mode_t        mode_reg  [NUM_PORTS];
    logic [LEN_W-1:0]  drun_reg  [NUM_PORTS];
    logic [LEN_W-1:0]  nenq_reg  [NUM_PORTS];
    logic [LEN_W-1:0]  nwin_reg  [NUM_PORTS];
    logic [BWIN_W-1:0] bwin_reg  [NUM_PORTS];
    logic [LEN_W-1:0]  dcnt_reg  [NUM_PORTS];
    logic [LEN_W-1:0]  plen_reg  [NUM_PORTS];

    event_t            evt_reg;
    logic [SUM_W-1:0]  occ_sum_reg;
    logic [BCW-1:0]    bcnt_reg;
    logic [IW-1:0]     idx_reg;
    logic [OCC_W-1:0]  normal_reg;
    logic [LEN_W-1:0]  share_reg;

    logic [IW-1:0]     addr;
    port_mode_t        cur_mode;
    logic [LEN_W-1:0]  cur_len;
    logic [OCC_W-1:0]  occ_sat;
    logic [OCC_W-1:0]  free_cnt;
    logic [PROD_W-1:0] prod;
    logic [2*LEN_W:0]  share_prod;
    logic [LEN_W-1:0]  div_q;
    logic              div_done;
    logic              div_start;
    logic              sweep_fire;
    logic              sweep_last;

    // Updated per-port values for the event
    port_mode_t        u_mode;
    logic [LEN_W-1:0]  u_drun, u_nenq, u_nwin, u_dcnt;
    logic [BWIN_W-1:0] u_bwin;
    logic [SUM_W-1:0]  u_occ;
    logic [BCW-1:0]    u_bcnt;

    // Sweep values
    logic [OCC_W-1:0]  th;
    logic              evac_exit;
    port_mode_t        rep_mode;

    // One access address: event port while updating, sweep index otherwise
    assign addr     = (state_reg == ST_UPDATE) ? IW'(evt_reg.port) : idx_reg;
    assign cur_mode = mode_reg[addr];
    assign cur_len  = plen_reg[addr];

    // Saturated occupancy and free space
    assign occ_sat  = (32'(occ_sum_reg) > 32'(2**OCC_W - 1)) ? {OCC_W{1'b1}}
                                                            : OCC_W'(occ_sum_reg);
    assign free_cnt = (OCC_W'(cfg.buffer_size) > occ_sat)
                      ? OCC_W'(cfg.buffer_size) - occ_sat : '0;
    assign prod     = cfg.alpha_q8 * free_cnt[LEN_W-1:0];

    // Scale buffer_size by the reciprocal of the port count
    assign share_prod = cfg.buffer_size * (LEN_W+1)'(SHR_M);

    // Apply one event to the counters and mode of its port
    always_comb
    begin
        u_mode = cur_mode;
        u_drun = drun_reg[addr];
        u_nenq = nenq_reg[addr];
        u_nwin = nwin_reg[addr];
        u_bwin = bwin_reg[addr];
        u_dcnt = dcnt_reg[addr];
        if (evt_reg.kind == KIND_DROP)
        begin
            if (occ_sat == OCC_W'(cfg.buffer_size))
            begin
                u_mode = MODE_NORMAL;
                u_bwin = '0;
            end
            u_nenq = '0;
            u_drun = '0;
            u_dcnt = u_dcnt + 1'b1;
            if (u_dcnt == cfg.drop_evac_limit)
            begin
                u_dcnt = '0;
                u_mode = MODE_EVAC;
            end
        end
        else
        begin
            if (evt_reg.old_length > evt_reg.new_length)
            begin
                u_drun = u_drun + 1'b1;
                if (u_drun == cfg.dequeue_run_limit)
                begin
                    u_drun = '0;
                    u_nenq = '0;
                    u_mode = MODE_NORMAL;
                    u_bwin = '0;
                    u_dcnt = '0;
                end
                if (u_nenq != '0)
                begin
                    u_nenq = u_nenq - 1'b1;
                end
                if (u_mode == MODE_NORMAL)
                begin
                    u_nwin = u_nwin + 1'b1;
                    if (u_nwin == cfg.normal_window_limit)
                    begin
                        u_nwin = '0;
                        u_nenq = '0;
                        u_drun = '0;
                    end
                end
                else if (u_mode == MODE_BURST)
                begin
                    u_bwin = u_bwin + 1'b1;
                    if (u_bwin == cfg.burst_window_limit)
                    begin
                        u_bwin = '0;
                        u_mode = MODE_NORMAL;
                    end
                end
            end
            else
            begin
                u_drun = '0;
                u_nenq = u_nenq + 1'b1;
                if (u_nenq == cfg.enqueue_burst_limit)
                begin
                    u_mode = MODE_BURST;
                end
            end
            if (u_mode == MODE_BURST)
            begin
                u_nenq = '0;
                u_nwin = '0;
            end
        end
        u_occ  = occ_sum_reg + SUM_W'(evt_reg.new_length) - SUM_W'(cur_len);
        u_bcnt = bcnt_reg + BCW'(u_mode == MODE_BURST) - BCW'(cur_mode == MODE_BURST);
    end

    // Pick the threshold of the swept port and test for evacuation exit
    always_comb
    begin
        th = normal_reg;
        if (cfg.mode_traffic_aware)
        begin
            if (cur_mode == MODE_BURST)
            begin
                th = (bcnt_reg != '0) ? OCC_W'(div_q) : '0;
            end
            else if (cur_mode == MODE_EVAC && th > OCC_W'(share_reg))
            begin
                th = OCC_W'(share_reg);
            end
        end
        evac_exit = (cur_mode == MODE_EVAC) && (th > OCC_W'({cur_len, 1'b0}));
        rep_mode  = evac_exit ? MODE_NORMAL : cur_mode;
    end

    assign sweep_last = (idx_reg == IW'(NUM_PORTS - 1));

    always_comb
    begin
        res.out_port  = PORT_W'(idx_reg);
        res.threshold = (th > OCC_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}} : th[LEN_W-1:0];
        res.out_mode  = rep_mode;
        res.last      = sweep_last;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!evt_empty)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = (evt_reg.kind == KIND_DROP) ? ST_IDLE : ST_CALC;
            end
            ST_CALC:
            begin
                state_next = (bcnt_reg != '0) ? ST_DIV : ST_SWEEP;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (!res_full && sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        evt_pop    = 1'b0;
        div_start  = 1'b0;
        sweep_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:   evt_pop    = !evt_empty;
            ST_CALC:   div_start  = (bcnt_reg != '0);
            ST_SWEEP:  sweep_fire = !res_full;
            default:   evt_pop    = 1'b0;
        endcase
    end

    assign res_push = sweep_fire;

    tabt_div #(
        .DW (BCW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cfg.buffer_size),
        .divisor  (bcnt_reg),
        .quotient (div_q),
        .done     (div_done)
    );

    // Hold control state and per-port state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            occ_sum_reg <= '0;
            bcnt_reg    <= '0;
            idx_reg     <= '0;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                mode_reg[i] <= MODE_NORMAL;
                drun_reg[i] <= '0;
                nenq_reg[i] <= '0;
                nwin_reg[i] <= '0;
                bwin_reg[i] <= '0;
                dcnt_reg[i] <= '0;
                plen_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_UPDATE)
            begin
                mode_reg[addr] <= u_mode;
                drun_reg[addr] <= u_drun;
                nenq_reg[addr] <= u_nenq;
                nwin_reg[addr] <= u_nwin;
                bwin_reg[addr] <= u_bwin;
                dcnt_reg[addr] <= u_dcnt;
                bcnt_reg       <= u_bcnt;
                if (evt_reg.kind == KIND_CHANGE)
                begin
                    plen_reg[addr] <= evt_reg.new_length;
                    occ_sum_reg    <= u_occ;
                end
            end
            if (state_reg == ST_CALC)
            begin
                idx_reg <= '0;
            end
            if (sweep_fire)
            begin
                idx_reg <= sweep_last ? '0 : idx_reg + 1'b1;
                if (evac_exit)
                begin
                    mode_reg[addr] <= MODE_NORMAL;
                    dcnt_reg[addr] <= '0;
                end
            end
        end
    end

    // Latch the event and the sweep-wide thresholds
    always_ff @(posedge clk)
    begin
        if (evt_pop)
        begin
            evt_reg <= evt_head;
        end
        if (state_reg == ST_CALC)
        begin
            normal_reg <= OCC_W'(prod >> 8);
            share_reg  <= LEN_W'(share_prod >> SHR_K);
        end
    end

`ifndef ASSERT_OFF
    a_push_only_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (state_reg == ST_SWEEP))
        else $error("result pushed outside sweep");
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        evt_pop |=> (state_reg == ST_UPDATE))
        else $error("event taken but no update followed");
    a_burst_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(bcnt_reg) <= NUM_PORTS)
        else $error("burst port count out of range");
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (bcnt_reg != '0))
        else $error("divider started with zero divisor");
`endif

endmodule
